// ----- hw/rtl/sssp_pkg.sv -----
package sssp_pkg;
    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int REQ_W   = 2;
    localparam int VTX_W   = 8;
    localparam int COST_W  = 16;
    localparam int NV_W    = 9;
    localparam int STAT_W  = 2;
    localparam int PATH_W  = 24;
    localparam int DIST_W  = 25;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;
endpackage

// ----- hw/rtl/sssp_if.sv -----
interface sssp_req_if;
    import sssp_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [VTX_W-1:0]    edge_from;
    logic [VTX_W-1:0]    edge_to;
    logic [COST_W-1:0]   edge_cost;
    logic [VTX_W-1:0]    start_vertex;
    logic [VTX_W-1:0]    goal_vertex;
    modport source (output valid, req_type, edge_from, edge_to, edge_cost,
                    start_vertex, goal_vertex, input ready);
    modport sink (input valid, req_type, edge_from, edge_to, edge_cost,
                  start_vertex, goal_vertex, output ready);
endinterface

interface sssp_rsp_if;
    import sssp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [PATH_W-1:0]   path_length;
    logic                reachable;
    modport source (output valid, status, path_length, reachable, input ready);
    modport sink (input valid, status, path_length, reachable, output ready);
endinterface

interface sssp_cfg_if;
    import sssp_pkg::*;
    logic             valid;
    logic             ready;
    logic [NV_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/single_source_shortest_path.sv -----
// Shortest-path engine. Load edges (one per transaction) into an edge
// memory, then issue a query: the block runs Dijkstra from start_vertex with
// a linear minimum scan and returns the goal's distance. Each reached vertex
// costs one pass over the distance memory (one read port) and one pass over
// the edge memory, and each relaxed edge a sum and a write-back. The
// distance memory is reset by a sweep over all MAX_VERTICES entries at query
// start. Input is not ready while a transaction is in progress or its
// response waits.
module single_source_shortest_path #(
    parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS  = sssp_pkg::WEIGHT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sssp_cfg_if.sink   i_cfg,
    sssp_req_if.sink   i_req,
    sssp_rsp_if.source o_rsp
);
    import sssp_pkg::*;

    localparam int VA_W = $clog2(MAX_VERTICES);
    localparam int VC_W = $clog2(MAX_VERTICES + 1);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam logic [DIST_W-1:0] DIST_CAP = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_SCAN, S_SCAN_LAST, S_PICK, S_EDGE, S_EDGE_WAIT,
        S_RELAX, S_RELAX_WR, S_GOAL, S_GOAL_WAIT, S_RESP
    } t_state;

    t_state r_state;

    logic [VC_W-1:0] r_nv;
    logic [EC_W-1:0] r_edge_cnt;

    // edge memory
    logic [VA_W-1:0]        r_esrc [MAX_EDGES];
    logic [VA_W-1:0]        r_edst [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] r_ewt  [MAX_EDGES];
    logic [VA_W-1:0]        r_esrc_q, r_edst_q;
    logic [WEIGHT_BITS-1:0] r_ewt_q;

    // per-vertex memory: {reached, finalized, distance}
    logic [DIST_W+1:0] r_vmem [MAX_VERTICES];
    logic [DIST_W+1:0] r_vq;
    logic              vm_we;
    logic [VA_W-1:0]   vm_waddr, vm_raddr;
    logic [DIST_W+1:0] vm_wdata;

    logic [VC_W-1:0]   r_vi;     // vertex sweep index
    logic [VA_W-1:0]   r_vprev;  // index of data in r_vq
    logic [EC_W-1:0]   r_ei;
    logic [VA_W-1:0]   r_start, r_goal, r_u;
    logic              r_found;
    logic [DIST_W-1:0] r_best;
    logic [DIST_W-1:0] r_cand;

    logic [STAT_W-1:0] r_status;
    logic [PATH_W-1:0] r_path;
    logic              r_reach;

    logic [VC_W-1:0] nv_eff;
    always_comb begin
        if (i_cfg.data == '0)
            nv_eff = VC_W'(1);
        else if (32'(i_cfg.data) > MAX_VERTICES)
            nv_eff = VC_W'(MAX_VERTICES);
        else
            nv_eff = VC_W'(i_cfg.data);
    end

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_nv <= VC_W'(MAX_VERTICES);
        else if (i_cfg.valid)
            r_nv <= nv_eff;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_RESP);
    assign o_rsp.status      = r_status;
    assign o_rsp.path_length = r_path;
    assign o_rsp.reachable   = r_reach;

    wire req_fire = i_req.valid && i_req.ready;
    wire [DIST_W:0] sum = {1'b0, r_best} + (DIST_W+1)'(r_ewt_q);

    // vertex memory port control
    always_comb begin
        vm_we    = 1'b0;
        vm_waddr = r_vi[VA_W-1:0];
        vm_wdata = '0;
        vm_raddr = r_vi[VA_W-1:0];
        unique case (r_state)
            S_INIT: begin
                vm_we    = 1'b1;
                vm_wdata = (r_vi[VA_W-1:0] == r_start) ? {2'b10, {DIST_W{1'b0}}} : '0;
            end
            S_PICK: begin
                vm_we    = r_found;
                vm_waddr = r_u;
                vm_wdata = {2'b11, r_best};
            end
            // hold the destination read until the write-back
            S_EDGE_WAIT, S_RELAX: vm_raddr = r_edst_q;
            S_RELAX_WR: begin
                vm_waddr = r_edst_q;
                vm_we    = !r_vq[DIST_W+1] || (r_vq[DIST_W-1:0] > r_cand);
                vm_wdata = {1'b1, r_vq[DIST_W], r_cand};
            end
            S_GOAL: vm_raddr = r_goal;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (vm_we)
            r_vmem[vm_waddr] <= vm_wdata;
        r_vq <= r_vmem[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.req_type == REQ_LOAD && r_state == S_IDLE
            && 32'(i_req.edge_from) < 32'(r_nv) && 32'(i_req.edge_to) < 32'(r_nv)
            && 32'(r_edge_cnt) < MAX_EDGES) begin
            r_esrc[r_edge_cnt[EA_W-1:0]] <= VA_W'(i_req.edge_from);
            r_edst[r_edge_cnt[EA_W-1:0]] <= VA_W'(i_req.edge_to);
            r_ewt[r_edge_cnt[EA_W-1:0]]  <= WEIGHT_BITS'(i_req.edge_cost);
        end
        r_esrc_q <= r_esrc[r_ei[EA_W-1:0]];
        r_edst_q <= r_edst[r_ei[EA_W-1:0]];
        r_ewt_q  <= r_ewt[r_ei[EA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_edge_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (req_fire) begin
                    r_status <= ST_OK;
                    r_path   <= '0;
                    r_reach  <= 1'b0;
                    r_start  <= VA_W'(i_req.start_vertex);
                    r_goal   <= VA_W'(i_req.goal_vertex);
                    r_vi     <= '0;
                    r_state  <= S_RESP;
                    case (i_req.req_type)
                        REQ_LOAD: begin
                            if (32'(i_req.edge_from) >= 32'(r_nv)
                                || 32'(i_req.edge_to) >= 32'(r_nv))
                                r_status <= ST_RANGE;
                            else if (32'(r_edge_cnt) >= MAX_EDGES)
                                r_status <= ST_FULL;
                            else
                                r_edge_cnt <= r_edge_cnt + EC_W'(1);
                        end
                        REQ_QUERY: begin
                            if (32'(i_req.start_vertex) >= 32'(r_nv)
                                || 32'(i_req.goal_vertex) >= 32'(r_nv))
                                r_status <= ST_RANGE;
                            else
                                r_state <= S_INIT;
                        end
                        REQ_CLEAR: r_edge_cnt <= '0;
                        default: ;
                    endcase
                end
                S_INIT: begin
                    r_vi <= r_vi + VC_W'(1);
                    if (r_vi == VC_W'(MAX_VERTICES - 1)) begin
                        r_vi    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN, S_SCAN_LAST: begin
                    // compare the previous cycle's read while issuing the next
                    if (r_state == S_SCAN_LAST || r_vi != '0) begin
                        if (r_vq[DIST_W+1] && !r_vq[DIST_W]
                            && (!r_found || r_vq[DIST_W-1:0] < r_best)) begin
                            r_found <= 1'b1;
                            r_best  <= r_vq[DIST_W-1:0];
                            r_u     <= r_vprev;
                        end
                    end
                    r_vprev <= r_vi[VA_W-1:0];
                    if (r_state == S_SCAN_LAST)
                        r_state <= S_PICK;
                    else if (r_vi == r_nv - VC_W'(1))
                        r_state <= S_SCAN_LAST;
                    else
                        r_vi <= r_vi + VC_W'(1);
                end
                S_PICK: begin
                    r_ei <= '0;
                    if (r_found)
                        r_state <= S_EDGE;
                    else
                        r_state <= S_GOAL;
                end
                S_EDGE: begin
                    if (r_ei == r_edge_cnt) begin
                        r_vi    <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else
                        r_state <= S_EDGE_WAIT;
                end
                S_EDGE_WAIT: begin
                    // hold the edge index while relaxing so its fields stay put
                    if (r_esrc_q == r_u && 32'(r_edst_q) < 32'(r_nv)) begin
                        r_state <= S_RELAX;
                    end else begin
                        r_ei    <= r_ei + EC_W'(1);
                        r_state <= S_EDGE;
                    end
                end
                S_RELAX: begin
                    r_cand  <= sum[DIST_W] ? DIST_CAP : sum[DIST_W-1:0];
                    r_state <= S_RELAX_WR;
                end
                S_RELAX_WR: begin
                    r_ei    <= r_ei + EC_W'(1);
                    r_state <= S_EDGE;
                end
                S_GOAL: r_state <= S_GOAL_WAIT;
                S_GOAL_WAIT: begin
                    if (r_vq[DIST_W+1]) begin
                        r_reach <= 1'b1;
                        r_path  <= r_vq[DIST_W-1] ? '1 : r_vq[PATH_W-1:0];
                    end
                    r_state <= S_RESP;
                end
                S_RESP: if (o_rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_cnt) <= MAX_EDGES) else $error("edge count overflow");
    a_nv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nv != '0 && 32'(r_nv) <= MAX_VERTICES) else $error("vertex count bad");
    a_resp_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.reachable |-> o_rsp.status == ST_OK)
        else $error("reachable with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.path_length))
        else $error("response dropped");
endmodule

// ----- test/single_source_shortest_path_test.sv -----
module single_source_shortest_path_test;
    import sssp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 4000000;
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
    localparam logic [PATH_W-1:0] PATH_SAT = {PATH_W{1'b1}};

    typedef struct {
        t_req             kind;
        logic [VTX_W-1:0]  from_v;
        logic [VTX_W-1:0]  to_v;
        logic [COST_W-1:0] cost;
        logic [VTX_W-1:0]  start_v;
        logic [VTX_W-1:0]  goal_v;
    } sp_request_t;

    typedef struct {
        t_status           status;
        logic [PATH_W-1:0] path_length;
        logic              reachable;
    } sp_answer_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sssp_cfg_if cfg_bus();
    sssp_req_if req_bus();
    sssp_rsp_if rsp_bus();

    single_source_shortest_path DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block state
    logic [NV_W-1:0]   shadow_nv = 9'd256;
    logic [VTX_W-1:0]  shadow_src [MAX_EDGES_DEF];
    logic [VTX_W-1:0]  shadow_dst [MAX_EDGES_DEF];
    logic [COST_W-1:0] shadow_wt  [MAX_EDGES_DEF];
    int                shadow_edges = 0;

    sp_request_t pending_requests[$];
    sp_answer_t  expected_answers[$];
    sp_request_t cur_request;

    int  error_count = 0;
    int  cycle_count = 0;
    int  queries_sent = 0;
    int  answers_seen = 0;
    bit  steady = 1'b0;
    int  hold_tokens = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    function automatic int active_vertices();
        int nv;
        nv = shadow_nv;
        if (nv == 0) nv = 1;
        if (nv > MAX_VERTICES_DEF) nv = MAX_VERTICES_DEF;
        return nv;
    endfunction

    function automatic sp_answer_t shortest_path_answer(sp_request_t rq);
        sp_answer_t      ans;
        int              nv, u;
        bit              found;
        logic [DIST_W-1:0] best;
        logic [DIST_W:0]   cand;
        logic [DIST_W-1:0] tent_dist [MAX_VERTICES_DEF];
        bit              reached [MAX_VERTICES_DEF];
        bit              done [MAX_VERTICES_DEF];
        nv = active_vertices();
        ans.status = ST_OK;
        ans.path_length = '0;
        ans.reachable = 1'b0;
        case (rq.kind)
            REQ_LOAD: begin
                if (rq.from_v >= nv || rq.to_v >= nv) begin
                    ans.status = ST_RANGE;
                end else if (shadow_edges >= MAX_EDGES_DEF) begin
                    ans.status = ST_FULL;
                end else begin
                    shadow_src[shadow_edges] = rq.from_v;
                    shadow_dst[shadow_edges] = rq.to_v;
                    shadow_wt[shadow_edges] = rq.cost;
                    shadow_edges++;
                end
            end
            REQ_QUERY: begin
                if (rq.start_v >= nv || rq.goal_v >= nv) begin
                    ans.status = ST_RANGE;
                end else begin
                    for (int v = 0; v < MAX_VERTICES_DEF; v++) begin
                        tent_dist[v] = '0;
                        reached[v] = 1'b0;
                        done[v] = 1'b0;
                    end
                    reached[rq.start_v] = 1'b1;
                    for (int it = 0; it < nv; it++) begin
                        found = 1'b0;
                        u = 0;
                        best = '0;
                        // lowest index wins a tie
                        for (int v = 0; v < nv; v++) begin
                            if (reached[v] && !done[v] && (!found || tent_dist[v] < best)) begin
                                found = 1'b1;
                                best = tent_dist[v];
                                u = v;
                            end
                        end
                        if (!found) break;
                        done[u] = 1'b1;
                        for (int e = 0; e < shadow_edges; e++) begin
                            if (shadow_src[e] == u && shadow_dst[e] < nv) begin
                                cand = best + shadow_wt[e];
                                if (cand > DIST_SAT) cand = DIST_SAT;
                                if (!reached[shadow_dst[e]] ||
                                    tent_dist[shadow_dst[e]] > cand) begin
                                    tent_dist[shadow_dst[e]] = cand[DIST_W-1:0];
                                    reached[shadow_dst[e]] = 1'b1;
                                end
                            end
                        end
                    end
                    if (reached[rq.goal_v]) begin
                        ans.reachable = 1'b1;
                        ans.path_length = (tent_dist[rq.goal_v] > PATH_SAT) ? PATH_SAT
                                        : tent_dist[rq.goal_v][PATH_W-1:0];
                    end
                end
            end
            REQ_CLEAR: shadow_edges = 0;
            default: ;
        endcase
        return ans;
    endfunction

    initial begin
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_NONE;
        req_bus.edge_from = '0;
        req_bus.edge_to = '0;
        req_bus.edge_cost = '0;
        req_bus.start_vertex = '0;
        req_bus.goal_vertex = '0;
        rsp_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_answers.push_back(shortest_path_answer(cur_request));
                if (cur_request.kind == REQ_QUERY) queries_sent++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_requests.size() > 0 && (steady || $urandom_range(99) >= 23)) begin
                    cur_request = pending_requests.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.req_type <= cur_request.kind;
                    req_bus.edge_from <= cur_request.from_v;
                    req_bus.edge_to <= cur_request.to_v;
                    req_bus.edge_cost <= cur_request.cost;
                    req_bus.start_vertex <= cur_request.start_v;
                    req_bus.goal_vertex <= cur_request.goal_v;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_tokens) begin
            hold_seen <= hold_tokens;
            hold_left <= 600;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        sp_answer_t exp_ans;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected response transaction");
                    error_count++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (rsp_bus.status !== exp_ans.status) begin
                        $error("status: expected %0d actual %0d", exp_ans.status,
                               rsp_bus.status);
                        error_count++;
                    end
                    if (rsp_bus.path_length !== exp_ans.path_length) begin
                        $error("path_length: expected %0d actual %0d",
                               exp_ans.path_length, rsp_bus.path_length);
                        error_count++;
                    end
                    if (rsp_bus.reachable !== exp_ans.reachable) begin
                        $error("reachable: expected %0d actual %0d", exp_ans.reachable,
                               rsp_bus.reachable);
                        error_count++;
                    end
                end
            end
            rsp_bus.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("single_source_shortest_path_test: done, errors");
            $finish;
        end
    end

    task automatic add_item(t_req k, int a, int b, int c);
        sp_request_t rq;
        rq.kind = k;
        rq.from_v = VTX_W'($urandom);
        rq.to_v = VTX_W'($urandom);
        rq.cost = COST_W'($urandom);
        rq.start_v = VTX_W'($urandom);
        rq.goal_v = VTX_W'($urandom);
        if (k == REQ_LOAD) begin
            rq.from_v = VTX_W'(a);
            rq.to_v = VTX_W'(b);
            rq.cost = COST_W'(c);
        end else if (k == REQ_QUERY) begin
            rq.start_v = VTX_W'(a);
            rq.goal_v = VTX_W'(b);
        end
        pending_requests.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || req_bus.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(int value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= NV_W'(value);
        do @(posedge i_clk); while (!cfg_bus.ready);
        shadow_nv = NV_W'(value);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int nv;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of 256: widest vertex range
        add_item(REQ_QUERY, 0, 255, 0);
        add_item(REQ_LOAD, 0, 255, 65535);
        add_item(REQ_LOAD, 255, 0, 0);
        add_item(REQ_QUERY, 0, 255, 0);
        add_item(REQ_NONE, 0, 0, 0);
        add_item(REQ_QUERY, 255, 255, 0);
        wait_drained();
        // above the maximum acts as the maximum
        write_vertex_count(300);
        add_item(REQ_QUERY, 255, 0, 0);
        wait_drained();
        // small graph: range errors, tie, zero weight, stale edges
        write_vertex_count(4);
        add_item(REQ_LOAD, 0, 9, 3);
        add_item(REQ_LOAD, 9, 0, 3);
        add_item(REQ_QUERY, 0, 7, 0);
        add_item(REQ_QUERY, 7, 0, 0);
        add_item(REQ_LOAD, 0, 1, 5);
        add_item(REQ_LOAD, 0, 2, 5);
        add_item(REQ_LOAD, 1, 3, 1);
        add_item(REQ_LOAD, 2, 3, 0);
        add_item(REQ_QUERY, 0, 3, 0);
        add_item(REQ_QUERY, 3, 0, 0);
        add_item(REQ_CLEAR, 0, 0, 0);
        add_item(REQ_QUERY, 0, 3, 0);
        wait_drained();
        // zero acts as one vertex
        write_vertex_count(0);
        add_item(REQ_LOAD, 0, 0, 7);
        add_item(REQ_QUERY, 0, 0, 0);
        add_item(REQ_LOAD, 0, 1, 7);
        wait_drained();

        // random phases: configure, sometimes clear, load a graph, query it
        for (int ph = 0; ph < 6; ph++) begin
            nv = ($urandom_range(7) == 0) ? 0 : $urandom_range(16, 1);
            write_vertex_count(nv);
            if (ph == 2) hold_tokens++;
            steady = (ph == 5);
            if (nv == 0) nv = 1;
            if ($urandom_range(3) != 0) add_item(REQ_CLEAR, 0, 0, 0);
            for (int i = 0; i < 12; i++) begin
                case ($urandom_range(9))
                    0: add_item(t_req'($urandom_range(3)), $urandom_range(255),
                                $urandom_range(255), $urandom);
                    1, 2, 3: add_item(REQ_QUERY, $urandom_range(nv - 1),
                                      $urandom_range(nv - 1), 0);
                    default: add_item(REQ_LOAD, $urandom_range(nv - 1),
                                      $urandom_range(nv - 1),
                                      ($urandom_range(3) == 0) ? $urandom
                                                               : $urandom_range(20));
                endcase
            end
            add_item(REQ_QUERY, $urandom_range(nv - 1), $urandom_range(nv - 1), 0);
            wait_drained();
        end
        steady = 1'b0;

        repeat (50) @(posedge i_clk);
        if (expected_answers.size() > 0) begin
            $error("%0d expected responses never arrived", expected_answers.size());
            error_count++;
        end
        $display("covered %0d responses, %0d queries, vertex counts 0 to 300, random graphs",
                 answers_seen, queries_sent);
        if (error_count == 0) begin
            $display("single_source_shortest_path_test: done, clean");
        end else begin
            $display("single_source_shortest_path_test: done, errors");
        end
        $finish;
    end
endmodule
